### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

### rtl/core/mtcd_pkg.sv
// Shared types, codes and defaults of the multitouch contact debouncer.
`timescale 1ns / 1ps

package mtcd_pkg;

    localparam int DEVICES_DEF = 8;
    localparam int SLOTS_DEF   = 64;

    localparam logic [15:0] DEBOUNCE_RST = 16'd100;

    typedef enum logic [1:0] {
        OP_EVENT      = 2'd0,
        OP_BATCH_END  = 2'd1,
        OP_TICK       = 2'd2,
        OP_SCREEN_OFF = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_FALLBACK = 2'd1,
        REG_DEV_CNT  = 2'd2
    } reg_idx_t;

    // evdev types
    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_ABS = 5'd3;

    // evdev codes
    localparam logic [9:0] CODE_DROP_SYNC   = 10'h003;
    localparam logic [9:0] CODE_TOUCH_KEY   = 10'h14a;
    localparam logic [9:0] CODE_SLOT_SELECT = 10'h02f;
    localparam logic [9:0] CODE_TRACK_ID    = 10'h039;

endpackage

### rtl/core/multitouch_contact_debouncer.sv
// Multitouch contact debouncer: takes one beat per cycle while the result register is
// free or drains. An accepted beat reads its device's slot entry (slot mask and current
// slot) from a registered-read memory; stage 1 then modifies the entry, writes it back
// and loads the result register when it fires, so a stall of m_ready holds the beat.
// Back-to-back beats of the same device are served by forwarding the write into the
// read. Batch flags, per-device contact bits, the down-since time and the touch state
// live in flip-flops. Screen off clears the registered devices' entries through
// per-entry valid bits, so no clearing pass is needed. Configuration uses an APB port
// with registers at 0x0 (debounce_ms), 0x4 (fallback_mask), 0x8 (device_count).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multitouch_contact_debouncer
    import mtcd_pkg::*;
#(
    parameter int DEVICES = DEVICES_DEF,
    parameter int SLOTS   = SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [2:0]         s_device,
    input  logic [4:0]         s_ev_type,
    input  logic [9:0]         s_ev_code,
    input  logic signed [31:0] s_ev_value,
    input  logic [47:0]        s_now_ms,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_touching,
    output logic               m_rate_update,
    output logic               m_time_refresh
);

    localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(DEVICES + 1);
    localparam int ENT_W  = SLOTS + SLOT_W;

    // configuration registers
    logic [15:0] debounce_reg;
    logic [7:0]  fallback_reg;
    logic [3:0]  dev_cnt_reg;

    // stage-1 item
    logic               s1_valid_reg;
    opcode_t            s1_opcode_reg;
    logic [2:0]         s1_device_reg;
    logic [4:0]         s1_type_reg;
    logic [9:0]         s1_code_reg;
    logic signed [31:0] s1_value_reg;
    logic [47:0]        s1_now_reg;

    // tracker state
    logic [DEVICES-1:0] contact_reg, contact_next;
    logic [DEVICES-1:0] ent_valid_reg, ent_valid_next;
    logic [47:0]        down_since_reg, down_since_next;
    logic               down_valid_reg, down_valid_next;
    logic               touch_reg, touch_next;
    logic               b_open_reg, b_open_next;
    logic               b_state_reg, b_state_next;
    logic               b_press_reg, b_press_next;
    logic               b_contact_reg, b_contact_next;

    // result register
    logic m_valid_reg;
    logic m_touching_reg;
    logic m_rate_reg;
    logic m_refresh_reg;

    logic               s_accept;
    logic               s1_fire;
    logic               cfg_write;
    logic [ENT_W-1:0]   rd_data;
    logic               wr_en;
    logic [DEV_W-1:0]   dev_idx;
    logic [ENT_W-1:0]   wr_data;
    logic [CNT_W-1:0]   reg_cnt;
    logic [DEVICES-1:0] reg_mask;
    logic               valid_dev;
    logic [47:0]        since_diff;
    logic               el_old;
    logic               raw_old;
    logic               rate_upd;
    logic               refresh;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
            fallback_reg <= '0;
            dev_cnt_reg  <= '0;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                REG_FALLBACK: fallback_reg <= pwdata[7:0];
                REG_DEV_CNT:  dev_cnt_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads.
    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            REG_FALLBACK: prdata = {24'd0, fallback_reg};
            REG_DEV_CNT:  prdata = {28'd0, dev_cnt_reg};
            default:      prdata = '0;
        endcase
    end

    // Handshake: stage 1 advances when the result register is free or drains.
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    mtcd_slot_ram #(
        .DEPTH  (DEVICES),
        .WIDTH  (ENT_W),
        .ADDR_W (DEV_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (DEV_W'(s_device)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (dev_idx),
        .wr_data (wr_data)
    );

    // Registered device count and its mask.
    always_comb begin
        if (5'(dev_cnt_reg) > 5'(DEVICES)) begin
            reg_cnt = CNT_W'(DEVICES);
        end else begin
            reg_cnt = CNT_W'(dev_cnt_reg);
        end
        for (int t = 0; t < DEVICES; t++) begin
            reg_mask[t] = (5'(t) < 5'(reg_cnt));
        end
    end

    assign dev_idx    = DEV_W'(s1_device_reg);
    assign valid_dev  = 5'(s1_device_reg) < 5'(reg_cnt);
    assign since_diff = s1_now_reg - down_since_reg;
    assign el_old     = since_diff >= {32'd0, debounce_reg};
    assign raw_old    = |(contact_reg & reg_mask);

    // Modify the entry and the tracker state for the item in stage 1.
    always_comb begin
        logic [ENT_W-1:0]  ent;
        logic [SLOTS-1:0]  smask;
        logic [SLOTS-1:0]  sbit;
        logic [SLOT_W-1:0] cur;
        logic              raw;
        logic              el;
        logic              eff;

        ent             = rd_data;
        smask           = '0;
        cur             = '0;
        sbit            = '0;
        raw             = 1'b0;
        el              = 1'b0;
        eff             = 1'b0;
        contact_next    = contact_reg;
        ent_valid_next  = ent_valid_reg;
        down_since_next = down_since_reg;
        down_valid_next = down_valid_reg;
        touch_next      = touch_reg;
        b_open_next     = b_open_reg;
        b_state_next    = b_state_reg;
        b_press_next    = b_press_reg;
        b_contact_next  = b_contact_reg;
        rate_upd        = 1'b0;
        refresh         = 1'b0;
        wr_en           = 1'b0;

        if (s1_fire && valid_dev) begin
            if (ent_valid_reg[dev_idx]) begin
                smask = ent[SLOTS-1:0];
                cur   = ent[ENT_W-1:SLOTS];
            end
        end

        // Promote a held contact, or drop a stale down-since.
        if (s1_fire && (s1_opcode_reg != OP_EVENT) && down_valid_reg && !touch_reg) begin
            if (raw_old && el_old) begin
                touch_next = 1'b1;
                refresh    = 1'b1;
                rate_upd   = 1'b1;
            end else if (!raw_old) begin
                down_valid_next = 1'b0;
            end
        end

        if (s1_fire) begin
            case (s1_opcode_reg)
                OP_EVENT: begin
                    if (valid_dev) begin
                        wr_en = 1'b1;
                        ent_valid_next[dev_idx] = 1'b1;
                        // Open a batch on its first event.
                        if (!b_open_reg) begin
                            b_open_next    = 1'b1;
                            b_state_next   = 1'b0;
                            b_press_next   = 1'b0;
                            b_contact_next = contact_reg[dev_idx];
                        end
                        if (s1_type_reg == EV_SYN) begin
                            if (s1_code_reg == CODE_DROP_SYNC) begin
                                smask          = '0;
                                cur            = '0;
                                b_state_next   = 1'b1;
                                b_contact_next = 1'b0;
                            end
                        end else if (s1_type_reg == EV_KEY && s1_code_reg == CODE_TOUCH_KEY) begin
                            if (s1_value_reg == 32'sd0 || s1_value_reg == 32'sd1) begin
                                b_state_next   = 1'b1;
                                b_contact_next = s1_value_reg[0];
                                if (s1_value_reg[0]) begin
                                    b_press_next = 1'b1;
                                end
                            end
                        end else if (fallback_reg[s1_device_reg] && s1_type_reg == EV_ABS) begin
                            if (s1_code_reg == CODE_SLOT_SELECT) begin
                                if (!s1_value_reg[31] &&
                                    ($unsigned(s1_value_reg) < 32'(SLOTS))) begin
                                    cur = s1_value_reg[SLOT_W-1:0];
                                end
                            end else if (s1_code_reg == CODE_TRACK_ID) begin
                                sbit         = {{(SLOTS-1){1'b0}}, 1'b1} << cur;
                                b_state_next = 1'b1;
                                if (!s1_value_reg[31]) begin
                                    smask        = smask | sbit;
                                    b_press_next = 1'b1;
                                end else begin
                                    smask = smask & ~sbit;
                                end
                                b_contact_next = |smask;
                            end
                        end
                    end
                end
                OP_BATCH_END: begin
                    if (valid_dev) begin
                        if (b_open_reg && b_state_reg) begin
                            contact_next[dev_idx] = b_contact_reg;
                            raw = |(contact_next & reg_mask);
                            el  = el_old;
                            if (raw) begin
                                if (!down_valid_next) begin
                                    down_valid_next = 1'b1;
                                    down_since_next = s1_now_reg;
                                    el = (debounce_reg == 16'd0);
                                end
                            end else begin
                                down_valid_next = 1'b0;
                            end
                            eff = raw && down_valid_next && el;
                            if (eff != touch_next) begin
                                touch_next = eff;
                                refresh    = 1'b1;
                                rate_upd   = 1'b1;
                            end else if (eff && b_press_reg) begin
                                refresh = 1'b1;
                            end else if (!raw && touch_next) begin
                                touch_next = 1'b0;
                                refresh    = 1'b1;
                                rate_upd   = 1'b1;
                            end
                        end
                        // Close the batch.
                        b_open_next    = 1'b0;
                        b_state_next   = 1'b0;
                        b_press_next   = 1'b0;
                        b_contact_next = 1'b0;
                    end
                end
                OP_TICK: begin
                    rate_upd = 1'b1;
                end
                OP_SCREEN_OFF: begin
                    // Drop the registered devices' slots and contacts.
                    for (int t = 0; t < DEVICES; t++) begin
                        if (reg_mask[t]) begin
                            contact_next[t]   = 1'b0;
                            ent_valid_next[t] = 1'b0;
                        end
                    end
                    down_valid_next = 1'b0;
                    down_since_next = '0;
                    b_open_next     = 1'b0;
                    b_state_next    = 1'b0;
                    b_press_next    = 1'b0;
                    b_contact_next  = 1'b0;
                    if (touch_next) begin
                        touch_next = 1'b0;
                        refresh    = 1'b1;
                        rate_upd   = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        wr_data = {cur, smask};
    end

    // Advance stage 1 and hold the tracker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            contact_reg    <= '0;
            ent_valid_reg  <= '0;
            down_valid_reg <= 1'b0;
            down_since_reg <= '0;
            touch_reg      <= 1'b0;
            b_open_reg     <= 1'b0;
            b_state_reg    <= 1'b0;
            b_press_reg    <= 1'b0;
            b_contact_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            contact_reg    <= contact_next;
            ent_valid_reg  <= ent_valid_next;
            down_valid_reg <= down_valid_next;
            down_since_reg <= down_since_next;
            touch_reg      <= touch_next;
            b_open_reg     <= b_open_next;
            b_state_reg    <= b_state_next;
            b_press_reg    <= b_press_next;
            b_contact_reg  <= b_contact_next;
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the accepted beat and the result payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_opcode_reg <= opcode_t'(s_opcode);
            s1_device_reg <= s_device;
            s1_type_reg   <= s_ev_type;
            s1_code_reg   <= s_ev_code;
            s1_value_reg  <= s_ev_value;
            s1_now_reg    <= s_now_ms;
        end
        if (s1_fire) begin
            m_touching_reg <= touch_next;
            m_rate_reg     <= rate_upd;
            m_refresh_reg  <= refresh;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_touching     = m_touching_reg;
    assign m_rate_update  = m_rate_reg;
    assign m_time_refresh = m_refresh_reg;

    `ASSERT_SAME(a_touch_needs_down, aclk, aresetn, touch_reg, down_valid_reg)
    `ASSERT_SAME(a_closed_batch_clear, aclk, aresetn, !b_open_reg, !b_state_reg && !b_press_reg && !b_contact_reg)
    `ASSERT_NEXT(a_result_tracks_state, aclk, aresetn, s1_fire, m_valid_reg && (m_touching_reg == touch_reg))
    `ASSERT_NEXT(a_stall_holds_item, aclk, aresetn, s1_valid_reg && !s1_fire, s1_valid_reg)

endmodule

### rtl/core/mtcd_slot_ram.sv
// Per-device slot memory with registered read and write-to-read forwarding.
`timescale 1ns / 1ps

module mtcd_slot_ram
    import mtcd_pkg::*;
#(
    parameter int DEPTH  = DEVICES_DEF,
    parameter int WIDTH  = SLOTS_DEF + 6,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write back the modified entry.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the entry; bypass the write landing on the same entry this edge.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
